// File: rtl/core/m3i_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared widths, types and constants of the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package m3i_pkg;

	localparam int M_W   = 16;             // Q8.8 matrix entry
	localparam int PR_W  = 2 * M_W;        // entry product, Q16.16
	localparam int COF_W = PR_W + 1;       // cofactor, Q17.16
	localparam int DP_W  = M_W + COF_W;    // entry times cofactor, Q25.24
	localparam int DET_W = DP_W + 1;       // determinant, Q26.24
	localparam int OUT_W = 32;             // Q16.16 result
	localparam int Q_W   = 34;             // quotient bits, one below the binary point
	localparam int N_W   = COF_W + 25;     // twice the scaled numerator
	localparam int CW    = DET_W + Q_W;    // compare width of the range check
	localparam int NE    = 9;              // entries of a matrix

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [Q_W-1:0]   Q_POS_MAX = Q_W'(64'h7FFF_FFFF);
	localparam logic [Q_W-1:0]   Q_NEG_MAX = Q_W'(64'h8000_0000);
	localparam logic [OUT_W-1:0] SAT_POS   = 32'h7FFF_FFFF;
	localparam logic [OUT_W-1:0] SAT_NEG   = 32'h8000_0000;

	typedef logic signed [M_W-1:0]   m_t;
	typedef logic signed [COF_W-1:0] cof_t;
	typedef logic signed [DET_W-1:0] det_t;
	typedef logic [OUT_W-1:0]        out_t;

	typedef struct packed {
		cof_t [NE-1:0] cof;
		det_t          det;
		logic          singular;
	} entry_t;

endpackage
`default_nettype wire

// File: rtl/core/m3i_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_front
// Cofactor and determinant pipeline; classifies singular matrices.
// ----------------------------------------------------------------------------
module m3i_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire m3i_pkg::m_t [m3i_pkg::NE-1:0]     in_m,
	input  wire logic                              full,
	output logic                                   push,
	output m3i_pkg::entry_t                        entry
);

	logic signed [m3i_pkg::PR_W-1:0] pa_c [m3i_pkg::NE];
	logic signed [m3i_pkg::PR_W-1:0] pb_c [m3i_pkg::NE];
	logic signed [m3i_pkg::PR_W-1:0] pa_s1 [m3i_pkg::NE];
	logic signed [m3i_pkg::PR_W-1:0] pb_s1 [m3i_pkg::NE];
	m3i_pkg::m_t                     c0_s1 [3];
	m3i_pkg::m_t                     c0_s2 [3];
	m3i_pkg::cof_t                   cof_s2 [m3i_pkg::NE];
	m3i_pkg::cof_t                   cof_s3 [m3i_pkg::NE];
	m3i_pkg::cof_t                   cof_s4 [m3i_pkg::NE];
	logic signed [m3i_pkg::DP_W-1:0] dp_s3 [3];
	m3i_pkg::det_t                   det_s4;
	logic                            v_s1, v_s2, v_s3, v_s4;
	logic                            en;

	assign en       = !(v_s4 && full);
	assign in_ready = en;
	assign push     = v_s4 && en;

	always_comb begin
		int r0, r1, c0, c1;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				r0 = (r == 0) ? 1 : 0;
				r1 = (r == 2) ? 1 : 2;
				c0 = (c == 0) ? 1 : 0;
				c1 = (c == 2) ? 1 : 2;
				pa_c[r*3+c] = m3i_pkg::PR_W'(in_m[r0*3+c0]) * m3i_pkg::PR_W'(in_m[r1*3+c1]);
				pb_c[r*3+c] = m3i_pkg::PR_W'(in_m[r0*3+c1]) * m3i_pkg::PR_W'(in_m[r1*3+c0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < m3i_pkg::NE; i++) begin
				pa_s1[i] <= pa_c[i];
				pb_s1[i] <= pb_c[i];
				// checkerboard sign on the minor
				if (((i / 3) + (i % 3)) % 2 == 1)
					cof_s2[i] <= m3i_pkg::COF_W'(pb_s1[i]) - m3i_pkg::COF_W'(pa_s1[i]);
				else
					cof_s2[i] <= m3i_pkg::COF_W'(pa_s1[i]) - m3i_pkg::COF_W'(pb_s1[i]);
				cof_s3[i] <= cof_s2[i];
				cof_s4[i] <= cof_s3[i];
			end
			for (int r = 0; r < 3; r++) begin
				c0_s1[r] <= in_m[r*3];
				c0_s2[r] <= c0_s1[r];
				dp_s3[r] <= m3i_pkg::DP_W'(c0_s2[r]) * m3i_pkg::DP_W'(cof_s2[r*3]);
			end
			det_s4 <= m3i_pkg::DET_W'(dp_s3[0]) + m3i_pkg::DET_W'(dp_s3[1])
				+ m3i_pkg::DET_W'(dp_s3[2]);
		end
	end

	always_comb begin
		for (int i = 0; i < m3i_pkg::NE; i++)
			entry.cof[i] = cof_s4[i];
		entry.det      = det_s4;
		entry.singular = (det_s4 == '0);
	end

endmodule
`default_nettype wire

// File: rtl/core/m3i_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_queue
// Short queue of classified matrices between front and back.
// ----------------------------------------------------------------------------
module m3i_queue #(
	parameter int DEPTH = m3i_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire m3i_pkg::entry_t wr_entry,
	output logic                 full,
	input  wire logic            pop,
	output logic                 empty,
	output m3i_pkg::entry_t      rd_entry
);

	localparam int PW = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	m3i_pkg::entry_t  mem [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

endmodule
`default_nettype wire

// File: rtl/core/m3i_div_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_div_lane
// Pipelined restoring divider for one entry: cofactor over determinant,
// rounded to nearest with ties away from zero, saturated to Q16.16.
// ----------------------------------------------------------------------------
module m3i_div_lane (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire m3i_pkg::cof_t cof,
	input  wire m3i_pkg::det_t det,
	output m3i_pkg::out_t      value,
	output logic               ovf
);

	localparam int QW = m3i_pkg::Q_W;

	logic [m3i_pkg::N_W-1:0]   rem_s [QW+1];
	logic [m3i_pkg::DET_W-1:0] den_s [QW+1];
	logic [QW-1:0]             quo_s [QW+1];
	logic                      neg_s [QW+1];
	logic                      big_s [QW+1];

	logic [m3i_pkg::COF_W-1:0] cof_mag;
	logic [m3i_pkg::DET_W-1:0] det_mag;
	logic [m3i_pkg::N_W-1:0]   num2;

	assign cof_mag = cof[m3i_pkg::COF_W-1] ? m3i_pkg::COF_W'(-cof) : m3i_pkg::COF_W'(cof);
	assign det_mag = det[m3i_pkg::DET_W-1] ? m3i_pkg::DET_W'(-det) : m3i_pkg::DET_W'(det);
	// twice the numerator: cofactor scaled by 2^24, once more for rounding
	assign num2    = {cof_mag, 25'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num2;
			den_s[0] <= det_mag;
			quo_s[0] <= '0;
			neg_s[0] <= cof[m3i_pkg::COF_W-1] ^ det[m3i_pkg::DET_W-1];
			// quotient would not fit the bits below
			big_s[0] <= m3i_pkg::CW'(num2) >= {det_mag, QW'(0)};
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_step
		localparam int K = QW - 1 - i;
		logic [m3i_pkg::CW-1:0] sh;
		logic                   ge;
		assign sh = m3i_pkg::CW'(den_s[i]) << K;
		assign ge = m3i_pkg::CW'(rem_s[i]) >= sh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? rem_s[i] - m3i_pkg::N_W'(sh) : rem_s[i];
				quo_s[i+1] <= {quo_s[i][QW-2:0], ge};
				den_s[i+1] <= den_s[i];
				neg_s[i+1] <= neg_s[i];
				big_s[i+1] <= big_s[i];
			end
		end
	end

	logic [QW:0]   t_inc;
	logic [QW-1:0] q;
	logic          neg;
	logic          sat;

	always_comb begin
		t_inc = {1'b0, quo_s[QW]} + 1'b1;
		q     = t_inc[QW:1];
		neg   = neg_s[QW] && (q != '0);
		sat   = big_s[QW] || (neg ? (q > m3i_pkg::Q_NEG_MAX) : (q > m3i_pkg::Q_POS_MAX));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf <= sat;
			if (sat)
				value <= neg ? m3i_pkg::SAT_NEG : m3i_pkg::SAT_POS;
			else
				value <= neg ? m3i_pkg::OUT_W'(-q) : m3i_pkg::OUT_W'(q);
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/m3i_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_back
// Nine divider lanes fed from the queue, ending in the output register.
// ----------------------------------------------------------------------------
module m3i_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          empty,
	input  wire m3i_pkg::entry_t               rd_entry,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output m3i_pkg::out_t [m3i_pkg::NE-1:0]    out_val,
	output logic                               out_singular,
	output logic                               out_ovf
);

	localparam int LAT = m3i_pkg::Q_W + 2;

	logic [LAT-1:0]         vld_q;
	logic [LAT-1:0]         sing_q;
	logic                   en;
	m3i_pkg::out_t          lane_val [m3i_pkg::NE];
	logic [m3i_pkg::NE-1:0] lane_ovf;

	assign en  = !vld_q[LAT-1] || out_ready;
	assign pop = en && !empty;

	for (genvar l = 0; l < m3i_pkg::NE; l++) begin : g_lane
		m3i_div_lane u_lane (
			.clk   (clk),
			.en    (en),
			.cof   (rd_entry.cof[l]),
			.det   (rd_entry.det),
			.value (lane_val[l]),
			.ovf   (lane_ovf[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], pop};
	end

	always_ff @(posedge clk) begin
		if (en)
			sing_q <= {sing_q[LAT-2:0], rd_entry.singular};
	end

	assign out_valid    = vld_q[LAT-1];
	assign out_singular = sing_q[LAT-1];
	assign out_ovf      = !sing_q[LAT-1] && (|lane_ovf);

	always_comb begin
		for (int l = 0; l < m3i_pkg::NE; l++)
			out_val[l] = sing_q[LAT-1] ? '0 : lane_val[l];
	end

	a_sing_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_singular |-> !out_ovf && out_val[0] == '0)
		else $error("singular word carries data");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_val[4]))
		else $error("stalled word changed");

endmodule
`default_nettype wire

// File: rtl/core/matrix3x3_inverse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 inverse by adjugate over determinant, Q8.8 in, Q16.16 out.
// ----------------------------------------------------------------------------
// Pipeline: four cofactor/determinant stages, the queue memory, 36 divider stages.
// Throughput: one matrix per cycle while m_tready is high, set by the
// one-bit-per-stage dividers.
// Reset: arst_n clears the pipeline valid bits and the queue; no word pending.
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
	parameter int QUEUE_DEPTH = m3i_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [143:0] s_tdata,  // m_r0c0, m_r0c1, ... m_r2c2, 16 bits each
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [287:0]      m_tdata,  // inv_r0c0, inv_r0c1, ... inv_r2c2, 32 bits each
	output logic [1:0]        m_tuser   // singular, overflow
);

	m3i_pkg::m_t [m3i_pkg::NE-1:0]   in_m;
	m3i_pkg::entry_t                 wr_entry, rd_entry;
	m3i_pkg::out_t [m3i_pkg::NE-1:0] res;
	logic push, pop, full, empty, singular, ovf;

	always_comb begin
		for (int i = 0; i < m3i_pkg::NE; i++)
			in_m[i] = s_tdata[i*m3i_pkg::M_W +: m3i_pkg::M_W];
	end

	m3i_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_m     (in_m),
		.full     (full),
		.push     (push),
		.entry    (wr_entry)
	);

	m3i_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.rd_entry (rd_entry)
	);

	m3i_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.rd_entry     (rd_entry),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_val      (res),
		.out_singular (singular),
		.out_ovf      (ovf)
	);

	// transpose: word at row j, column i takes cofactor (i,j)
	always_comb begin
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				m_tdata[(c*3+r)*m3i_pkg::OUT_W +: m3i_pkg::OUT_W] = res[r*3+c];
	end

	assign m_tuser = {ovf, singular};

endmodule
`default_nettype wire
